### rtl/core/chf_pkg.sv
// ----------------------------------------------------------------------------
// chf_pkg
// Types, constants and the arctangent table shared by the heading pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chf_pkg;

	// coordinate width: 16-bit reading scaled by 2^24, plus CORDIC gain headroom
	localparam int CW = 45;
	// angle accumulator width, units of 2^-16 centidegree
	localparam int ZW = 32;
	localparam int ATAN_LEN = 24;
	localparam int FRAC_BITS = 16;
	localparam int SCALE_BITS = 24;

	localparam logic signed [ZW-1:0] QUARTER_UNITS = 32'sd589824000; // 90.00 deg
	localparam logic signed [ZW-1:0] ROUND_HALF = 32'sd32768;
	localparam logic signed [16:0] CENTIDEG_HALF = 17'sd18000;
	localparam logic signed [16:0] CENTIDEG_FULL = 17'sd36000;
	localparam logic [15:0] HEADING_NO_FIELD = 16'd18000;

	typedef struct packed {
		logic                 no_field;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// atan(2^-i) in 2^-16 centidegree units, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_units(input int idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			0:  v = 32'sd294912000;
			1:  v = 32'sd174096719;
			2:  v = 32'sd91987925;
			3:  v = 32'sd46694507;
			4:  v = 32'sd23437865;
			5:  v = 32'sd11730358;
			6:  v = 32'sd5866610;
			7:  v = 32'sd2933484;
			8:  v = 32'sd1466764;
			9:  v = 32'sd733385;
			10: v = 32'sd366693;
			11: v = 32'sd183346;
			12: v = 32'sd91673;
			13: v = 32'sd45837;
			14: v = 32'sd22918;
			15: v = 32'sd11459;
			16: v = 32'sd5730;
			17: v = 32'sd2865;
			18: v = 32'sd1432;
			19: v = 32'sd716;
			20: v = 32'sd358;
			21: v = 32'sd179;
			22: v = 32'sd90;
			23: v = 32'sd45;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/chf_prerot.sv
// ----------------------------------------------------------------------------
// chf_prerot
// Entry stage: scales the readings, folds the left half-plane into the right
// half-plane and registers the starting vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_prerot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	output logic               in_rdy,
	input  logic signed [15:0] x_field,
	input  logic signed [15:0] y_field,
	output logic               out_vld,
	input  logic               out_rdy,
	output chf_pkg::cordic_t   out_data
);

	logic             vld_s1;
	chf_pkg::cordic_t data_s1;
	chf_pkg::cordic_t nxt;
	logic             adv;
	logic signed [chf_pkg::CW-1:0] xs;
	logic signed [chf_pkg::CW-1:0] ys;

	assign adv    = !vld_s1 || out_rdy;
	assign in_rdy = adv;

	assign xs = {{(chf_pkg::CW-16-chf_pkg::SCALE_BITS){x_field[15]}}, x_field,
		{chf_pkg::SCALE_BITS{1'b0}}};
	assign ys = {{(chf_pkg::CW-16-chf_pkg::SCALE_BITS){y_field[15]}}, y_field,
		{chf_pkg::SCALE_BITS{1'b0}}};

	always_comb begin
		nxt.no_field = (x_field == 16'sd0) && (y_field == 16'sd0);
		if (x_field[15]) begin
			if (!y_field[15]) begin
				// rotate by -90 deg
				nxt.x = ys;
				nxt.y = -xs;
				nxt.z = chf_pkg::QUARTER_UNITS;
			end else begin
				// rotate by +90 deg
				nxt.x = -ys;
				nxt.y = xs;
				nxt.z = -chf_pkg::QUARTER_UNITS;
			end
		end else begin
			nxt.x = xs;
			nxt.y = ys;
			nxt.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			data_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

### rtl/core/chf_cell.sv
// ----------------------------------------------------------------------------
// chf_cell
// One vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	output logic             in_rdy,
	input  chf_pkg::cordic_t in_data,
	output logic             out_vld,
	input  logic             out_rdy,
	output chf_pkg::cordic_t out_data
);

	localparam logic signed [chf_pkg::ZW-1:0] ATAN_STEP = chf_pkg::atan_units(IDX);

	logic             vld_s1;
	chf_pkg::cordic_t data_s1;
	chf_pkg::cordic_t nxt;
	logic             adv;
	logic signed [chf_pkg::CW-1:0] dx;
	logic signed [chf_pkg::CW-1:0] dy;

	assign adv    = !vld_s1 || out_rdy;
	assign in_rdy = adv;

	assign dx = in_data.y >>> IDX;
	assign dy = in_data.x >>> IDX;

	always_comb begin
		nxt.no_field = in_data.no_field;
		if (!in_data.y[chf_pkg::CW-1]) begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + ATAN_STEP;
		end else begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			data_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

### rtl/core/chf_round.sv
// ----------------------------------------------------------------------------
// chf_round
// Output stage: rounds the angle to centidegrees, subtracts 180.00 deg,
// wraps into 0..359.99 and holds the result for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_round (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	output logic             in_rdy,
	input  chf_pkg::cordic_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      heading_centideg,
	output logic             no_field
);

	logic              vld_q;
	logic [15:0]       heading_q;
	logic              nf_q;
	logic              adv;
	logic signed [chf_pkg::ZW-1:0] z_rnd;
	logic signed [15:0] t_cd;
	logic signed [16:0] h_raw;
	logic signed [16:0] h_wrap;
	logic [15:0]        heading_nxt;

	assign adv    = !vld_q || !out_stall;
	assign in_rdy = adv;

	// round to nearest centidegree, ties up
	assign z_rnd = in_data.z + chf_pkg::ROUND_HALF;
	assign t_cd  = z_rnd[chf_pkg::ZW-1:chf_pkg::FRAC_BITS];
	assign h_raw = {t_cd[15], t_cd} + chf_pkg::CENTIDEG_HALF;

	always_comb begin
		priority if (h_raw < 17'sd0) begin
			h_wrap = h_raw + chf_pkg::CENTIDEG_FULL;
		end else if (h_raw >= chf_pkg::CENTIDEG_FULL) begin
			h_wrap = h_raw - chf_pkg::CENTIDEG_FULL;
		end else begin
			h_wrap = h_raw;
		end
		heading_nxt = in_data.no_field ? chf_pkg::HEADING_NO_FIELD : h_wrap[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			heading_q <= heading_nxt;
			nf_q      <= in_data.no_field;
		end
	end

	assign out_valid        = vld_q;
	assign heading_centideg = heading_q;
	assign no_field         = nf_q;

endmodule

### rtl/core/compass_heading_from_xy_field.sv
// ----------------------------------------------------------------------------
// compass_heading_from_xy_field
// Turns one signed X/Y magnetometer reading pair into a compass heading in
// hundredths of a degree: atan2(y, x) minus 180.00 deg, wrapped to
// 0..359.99. The angle comes from a pipelined CORDIC in vectoring mode, one
// registered cell per micro-rotation. Throughput is one request per clock
// while the output is not stalled; the pipeline runs through the entry
// stage, one cell per micro-rotation and the output register.
// Every stage holds its request when the stage after it is full and stalled,
// so empty slots in the chain fill up while a result waits at the output.
// When both readings are zero the heading reads 180.00 deg and no_field is
// set. The block keeps no state between requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compass_heading_from_xy_field #(
	parameter int ANGLE_ITERATIONS = 16   // 8..24 micro-rotations
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_field,
	input  logic signed [15:0] y_field,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        heading_centideg,
	output logic               no_field
);

	// link k feeds cell k; link ANGLE_ITERATIONS feeds the output stage
	logic             lnk_vld  [ANGLE_ITERATIONS+1];
	logic             lnk_rdy  [ANGLE_ITERATIONS+1];
	chf_pkg::cordic_t lnk_data [ANGLE_ITERATIONS+1];
	logic             pre_rdy;

	assign in_stall = !pre_rdy;

	// scaling and half-plane fold
	chf_prerot u_prerot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_valid),
		.in_rdy   (pre_rdy),
		.x_field  (x_field),
		.y_field  (y_field),
		.out_vld  (lnk_vld[0]),
		.out_rdy  (lnk_rdy[0]),
		.out_data (lnk_data[0])
	);

	// chain of micro-rotation cells, cell k shifts by k
	for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cell
		chf_cell #(
			.IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (lnk_vld[k]),
			.in_rdy   (lnk_rdy[k]),
			.in_data  (lnk_data[k]),
			.out_vld  (lnk_vld[k+1]),
			.out_rdy  (lnk_rdy[k+1]),
			.out_data (lnk_data[k+1])
		);
	end

	// rounding, 180 deg offset, wrap, output register
	chf_round u_round (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_vld           (lnk_vld[ANGLE_ITERATIONS]),
		.in_rdy           (lnk_rdy[ANGLE_ITERATIONS]),
		.in_data          (lnk_data[ANGLE_ITERATIONS]),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.heading_centideg (heading_centideg),
		.no_field         (no_field)
	);

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for compass_heading_from_xy_field. An in-bench CORDIC
// predictor computes the expected heading and the zero-field flag for every
// accepted X/Y request. A checker compares each result, in order, against
// the oldest expectation. Directed corners come first. Random requests then
// run under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int ANGLE_ITERATIONS = 16;
	// entry stage + one cell per micro-rotation + output register
	localparam int PIPE_LATENCY = ANGLE_ITERATIONS + 2;
	localparam int ATAN_STEPS = 24;

	// heading arithmetic, angle units are 2^-16 centidegree
	localparam longint UNITS_PER_CD = 64'sd65536;
	localparam longint CD_FULL = 64'sd36000;
	localparam longint CD_HALF = 64'sd18000;
	localparam longint CD_QUARTER = 64'sd9000;
	localparam logic [15:0] HEADING_UNDEFINED = 16'd18000;

	// extremes of a signed 16-bit reading
	localparam logic signed [15:0] READ_MAX = 16'sh7FFF;
	localparam logic signed [15:0] READ_MIN = 16'sh8000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] x_field;
	logic signed [15:0] y_field;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        heading_centideg;
	logic               no_field;

	// one pending heading, with the request that caused it for messages
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        heading;
		logic               no_field;
	} heading_expect_t;

	heading_expect_t pending_headings[$];

	// atan(2^-i) in angle units, rounded to nearest
	longint atan_step_units [ATAN_STEPS] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
		5866610, 2933484, 1466764, 733385, 366693, 183346,
		91673, 45837, 22918, 11459, 5730, 2865,
		1432, 716, 358, 179, 90, 45
	};

	int error_count;
	int requests_sent;
	int headings_checked;
	int zero_field_seen;
	int idle_pct;    // chance per cycle that the sender holds off
	int stall_pct;   // chance per cycle that the receiver stalls

	compass_heading_from_xy_field #(
		.ANGLE_ITERATIONS(ANGLE_ITERATIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_field(x_field),
		.y_field(y_field),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heading_centideg(heading_centideg),
		.no_field(no_field)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (~450 requests, even under
	// the heaviest stall mix).
	initial begin
		#4_000_000;
		$display("testbench failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Heading predictor: vectoring CORDIC on 64-bit integers.
	// Readings scaled by 2^24; the left half-plane is folded into the right
	// one by a +/-90 deg pre-rotation. Shifts are arithmetic (floor).
	// ------------------------------------------------------------------------
	function automatic heading_expect_t predict_heading(
		input logic signed [15:0] xr,
		input logic signed [15:0] yr
	);
		heading_expect_t res;
		longint vx, vy, ang, swap, dx, dy, shifted, cd;

		res.x = xr;
		res.y = yr;
		// both axes zero: angle undefined, forced to 180.00 deg, flagged
		if (xr == 0 && yr == 0) begin
			res.heading = HEADING_UNDEFINED;
			res.no_field = 1'b1;
			return res;
		end

		vx = longint'(xr) * (64'sd1 <<< 24);
		vy = longint'(yr) * (64'sd1 <<< 24);
		ang = 0;

		if (vx < 0) begin
			swap = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -swap;
				ang = CD_QUARTER * UNITS_PER_CD;
			end else begin
				vx = -vy;
				vy = swap;
				ang = -CD_QUARTER * UNITS_PER_CD;
			end
		end

		for (int i = 0; i < ANGLE_ITERATIONS && i < ATAN_STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx = vx + dx;
				vy = vy - dy;
				ang = ang + atan_step_units[i];
			end else begin
				vx = vx - dx;
				vy = vy + dy;
				ang = ang - atan_step_units[i];
			end
		end

		// lift to non-negative, round half up to centidegrees, rotate by 180, wrap
		shifted = ang + CD_FULL * UNITS_PER_CD;
		cd = (shifted + UNITS_PER_CD / 2) >>> 16;
		cd = (cd + CD_HALF) % CD_FULL;

		res.heading = cd[15:0];
		res.no_field = 1'b0;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Request side. Called just after the clock rises; returns as soon as the
	// request has been accepted. in_valid stays high between back-to-back requests.
	// ------------------------------------------------------------------------
	task automatic send_reading(input logic signed [15:0] xr, input logic signed [15:0] yr);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		x_field <= xr;
		y_field <= yr;
		do @(posedge clk); while (in_stall);
		pending_headings.push_back(predict_heading(xr, yr));
		requests_sent++;
	endtask

	// Sender holds off until every outstanding heading has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Receiver stall: re-rolled every cycle against the current mix.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// ------------------------------------------------------------------------
	// Result checker: in-order compare against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		heading_expect_t exp_h;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_headings.size() == 0) begin
				$display("%0t: unexpected result heading=%0d no_field=%0b",
					$time, heading_centideg, no_field);
				error_count++;
			end else begin
				exp_h = pending_headings.pop_front();
				headings_checked++;
				if (exp_h.no_field)
					zero_field_seen++;
				if (heading_centideg !== exp_h.heading) begin
					$display("%0t: heading mismatch x=%0d y=%0d expected %0d actual %0d",
						$time, exp_h.x, exp_h.y, exp_h.heading, heading_centideg);
					error_count++;
				end
				if (no_field !== exp_h.no_field) begin
					$display("%0t: no_field mismatch x=%0d y=%0d expected %0b actual %0b",
						$time, exp_h.x, exp_h.y, exp_h.no_field, no_field);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Axes, diagonals, full-scale readings, unit vectors, zero field and the
	// negative X axis (heading near 0).
	task automatic test_directed_corners();
		idle_pct = 0;
		stall_pct = 0;
		send_reading(16'sd0, 16'sd0);
		send_reading(READ_MAX, 16'sd0);
		send_reading(READ_MIN, 16'sd0);
		send_reading(16'sd0, READ_MAX);
		send_reading(16'sd0, READ_MIN);
		send_reading(READ_MAX, READ_MAX);
		send_reading(READ_MIN, READ_MIN);
		send_reading(READ_MIN, READ_MAX);
		send_reading(READ_MAX, READ_MIN);
		send_reading(16'sd1, 16'sd0);
		send_reading(-16'sd1, 16'sd0);
		send_reading(16'sd0, 16'sd1);
		send_reading(16'sd0, -16'sd1);
		send_reading(-16'sd1, -16'sd1);
		send_reading(-16'sd1, 16'sd1);
		send_reading(16'sd1, -16'sd1);
		send_reading(-16'sd5, 16'sd0);
		send_reading(READ_MIN, -16'sd1);  // just below the negative X axis
		send_reading(READ_MIN, 16'sd1);   // just above it
		send_reading(-16'sd1, READ_MIN);
		send_reading(16'sd0, 16'sd0);
		send_reading(16'sd12345, -16'sd23456);
	endtask

	// Random readings: mostly full range, plus tiny vectors (zero field and
	// coarse angles), single-axis readings and full-scale extremes.
	task automatic test_random_headings(input int count, input int idle, input int stall);
		logic signed [15:0] xr, yr;
		int kind;
		idle_pct = idle;
		stall_pct = stall;
		repeat (count) begin
			kind = $urandom_range(99);
			xr = 16'($urandom);
			yr = 16'($urandom);
			if (kind < 10) begin
				xr = $signed(16'($urandom_range(8))) - 16'sd4;
				yr = $signed(16'($urandom_range(8))) - 16'sd4;
			end else if (kind < 20) begin
				if ($urandom_range(1))
					xr = 16'sd0;
				else
					yr = 16'sd0;
			end else if (kind < 28) begin
				xr = $urandom_range(1) ? READ_MAX : READ_MIN;
				if ($urandom_range(1))
					yr = $urandom_range(1) ? READ_MAX : READ_MIN;
			end
			send_reading(xr, yr);
		end
	endtask

	// Short burst, then let the whole pipe empty before moving on.
	task automatic test_drain_pause();
		test_random_headings(12, 0, 0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_field = '0;
		y_field = '0;
		error_count = 0;
		requests_sent = 0;
		headings_checked = 0;
		zero_field_seen = 0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_drain_pause();
		test_random_headings(100, 0, 0);    // full rate, no stalls
		test_random_headings(100, 65, 0);   // sparse requests
		test_drain_pause();
		test_random_headings(100, 0, 65);   // heavy back-pressure
		test_random_headings(100, 24, 24);  // both sides bursty

		// flush: nothing left in flight, then allow for stray results
		wait_drained();
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		$display("Sent %0d X/Y requests over four idle/stall mixes with drain pauses;",
			requests_sent);
		$display("checked %0d headings, %0d of them zero-field, %0d errors.",
			headings_checked, zero_field_seen, error_count);
		if (error_count == 0 && pending_headings.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
